// ----- hw/rtl/rgbfg_pkg.sv -----
// Shared constants, codes and types for the LED strip frame generator.
package rgbfg_pkg;

    // Default strip length
    localparam int LED_COUNT_DEF = 3;

    // Stream framing
    localparam int          CHANNELS     = 3;
    localparam int          FRAME_WORDS  = 4;
    localparam logic [7:0]  START_BYTE   = 8'h00;
    localparam logic [7:0]  HEADER_MARK  = 8'hE0;
    localparam logic [7:0]  END_BYTE     = 8'hFF;
    localparam logic [4:0]  BRIGHT_RESET = 5'b00001;

    // Colour channel codes, also the entry offset inside one LED's row
    typedef logic [1:0] t_chan;
    localparam t_chan CH_RED   = 2'd0;
    localparam t_chan CH_GREEN = 2'd1;
    localparam t_chan CH_BLUE  = 2'd2;

    // Byte slots inside one LED frame
    typedef logic [1:0] t_slot;
    localparam t_slot SLOT_HDR   = 2'd0;
    localparam t_slot SLOT_BLUE  = 2'd1;
    localparam t_slot SLOT_GREEN = 2'd2;
    localparam t_slot SLOT_RED   = 2'd3;

    // Kind of byte travelling down the read pipeline
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_START  = 2'd0;
    localparam t_kind KIND_HEADER = 2'd1;
    localparam t_kind KIND_COLOUR = 2'd2;
    localparam t_kind KIND_END    = 2'd3;

    // One pipeline slot between read issue and output register
    typedef struct packed {
        logic  valid;
        t_kind kind;
        logic  last;
    } t_stage;

endpackage

// ----- hw/rtl/rgb_led_strip_frame_generator_top.sv -----
// Top level of the LED strip frame generator.
// Input channel (i_in_valid / o_in_stall): one transfer is one refresh carrying
// the channel button, the LED button and an 8-bit sample. On acceptance the
// selected channel steps on a channel press (or else the LED on an LED press)
// and the sample is written into the colour store at the newly selected entry.
// Output channel (o_out_valid / i_out_stall): each refresh produces
// 8 + 4*LED_COUNT bytes: four start bytes, per LED a header with the current
// brightness then blue, green, red, and four end bytes; o_last_byte flags the
// final end byte.
// Throughput: the frame sequencer issues one byte per cycle while the output
// is not stalled, through the single read port of the colour RAM. The next
// refresh is taken in the cycle the last byte of the current one is issued.
// Path: a refresh starts the byte counter; each byte then passes the read stage and the output register.
// Stalls: a stalled output register holds its byte and the sequencer pauses;
// the RAM read register holds its data until the pipeline moves again.
// Configuration (i_cfg_valid / o_cfg_ready): writes the 5-bit brightness,
// always ready; write it only while idle.
// Reset (synchronous, active low): brightness 1, red channel and first LED
// selected, all colours read as zero, no bytes pending.
module rgb_led_strip_frame_generator_top #(
    parameter int LED_COUNT = rgbfg_pkg::LED_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_channel_press,
    input  logic       i_led_press,
    input  logic [7:0] i_sample,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_stream_byte,
    output logic       o_last_byte,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [4:0] i_cfg_data
);

    import rgbfg_pkg::*;

    localparam int DEPTH  = CHANNELS * LED_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LED_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    logic [4:0]       r_brightness;
    logic [LED_W-1:0] r_sel_led;
    logic [LED_W-1:0] n_sel_led;
    t_chan            r_sel_chan;
    t_chan            n_sel_chan;

    logic              in_accept;
    logic              seq_ready;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    assign in_accept   = i_in_valid && seq_ready;
    assign o_in_stall  = !seq_ready;
    assign o_cfg_ready = 1'b1;

    // Brightness register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= BRIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_brightness <= i_cfg_data;
        end
    end

    // Step the channel on a channel press, otherwise the LED on an LED press
    always_comb begin
        n_sel_chan = r_sel_chan;
        n_sel_led  = r_sel_led;
        if (i_channel_press) begin
            n_sel_chan = (r_sel_chan == CH_BLUE) ? CH_RED : r_sel_chan + 2'd1;
        end else if (i_led_press) begin
            n_sel_led = (r_sel_led == LED_W'(LED_COUNT - 1)) ? '0 : r_sel_led + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel_chan <= CH_RED;
            r_sel_led  <= '0;
        end else if (in_accept) begin
            r_sel_chan <= n_sel_chan;
            r_sel_led  <= n_sel_led;
        end
    end

    // Entry address: three entries per LED
    assign wr_addr = ADDR_W'({n_sel_led, 1'b0}) + ADDR_W'(n_sel_led) + ADDR_W'(n_sel_chan);

    rgbfg_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (in_accept),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    rgbfg_seq #(
        .LED_COUNT (LED_COUNT)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_accept),
        .i_brightness (r_brightness),
        .o_ready      (seq_ready),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_valid      (o_out_valid),
        .i_stall      (i_out_stall),
        .o_byte       (o_stream_byte),
        .o_last       (o_last_byte)
    );

endmodule

// ----- hw/rtl/rgbfg_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module rgbfg_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 4,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/rgbfg_store.sv -----
// Colour store: RAM plus per-entry written flags so unwritten entries read as zero.
module rgbfg_store #(
    parameter  int DEPTH  = 9,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [DEPTH-1:0] r_written;
    logic             r_rd_hit;
    logic [7:0]       ram_q;

    rgbfg_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_addr),
        .i_wr_data (i_wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    // Mark entries on write; clear all marks at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr_en) begin
            r_written[i_wr_addr] <= 1'b1;
        end
    end

    // Capture the mark alongside the RAM read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_hit <= r_written[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_hit ? ram_q : 8'h00;

endmodule

// ----- hw/rtl/rgbfg_seq.sv -----
// Frame sequencer: walks the stream bytes, reads colours, drives the output register.
module rgbfg_seq #(
    parameter  int LED_COUNT = 3,
    localparam int DEPTH     = 3 * LED_COUNT,
    localparam int ADDR_W    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [4:0]        i_brightness,
    output logic              o_ready,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]        i_rd_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_byte,
    output logic              o_last
);

    import rgbfg_pkg::*;

    localparam int TOTAL     = 2 * FRAME_WORDS + 4 * LED_COUNT;
    localparam int CNT_W     = $clog2(TOTAL);
    localparam int LED_START = FRAME_WORDS;
    localparam int LED_END   = FRAME_WORDS + 4 * LED_COUNT;

    logic             r_busy;
    logic [CNT_W-1:0] r_idx;
    t_stage           r_s1;
    t_stage           n_s1;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic             advance;
    logic             issue;
    logic             final_idx;
    logic [CNT_W-1:0] led_ofs;
    logic [CNT_W-1:0] led_num;
    logic [CNT_W-1:0] row_base;
    t_slot            slot;
    t_chan            chan_ofs;
    logic [7:0]       n_byte;

    // Output register frees when empty or taken this cycle
    assign advance   = !r_out_valid || !i_stall;
    assign issue     = r_busy && advance;
    assign final_idx = (r_idx == CNT_W'(TOTAL - 1));
    assign o_ready   = !r_busy || (issue && final_idx);

    // Decode the byte index into LED number and slot
    assign led_ofs  = r_idx - CNT_W'(LED_START);
    assign led_num  = led_ofs >> 2;
    assign slot     = t_slot'(led_ofs[1:0]);
    assign row_base = (led_num << 1) + led_num;

    always_comb begin
        case (slot)
            SLOT_BLUE:  chan_ofs = CH_BLUE;
            SLOT_GREEN: chan_ofs = CH_GREEN;
            default:    chan_ofs = CH_RED;
        endcase
    end

    // Classify the byte being issued
    always_comb begin
        n_s1       = '0;
        n_s1.valid = 1'b1;
        n_s1.last  = final_idx;
        if (r_idx < CNT_W'(LED_START)) begin
            n_s1.kind = KIND_START;
        end else if (r_idx < CNT_W'(LED_END)) begin
            n_s1.kind = (slot == SLOT_HDR) ? KIND_HEADER : KIND_COLOUR;
        end else begin
            n_s1.kind = KIND_END;
        end
    end

    assign o_rd_en   = issue && (n_s1.kind == KIND_COLOUR);
    assign o_rd_addr = ADDR_W'(row_base + CNT_W'(chan_ofs));

    // Step the byte counter; a new frame restarts it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (issue) begin
            r_busy <= !final_idx;
            r_idx  <= r_idx + 1'b1;
        end
    end

    // Advance the read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (advance) begin
            r_s1 <= issue ? n_s1 : '0;
        end
    end

    // Compose the byte from the stage kind and the read data
    always_comb begin
        case (r_s1.kind)
            KIND_START:  n_byte = START_BYTE;
            KIND_HEADER: n_byte = HEADER_MARK | {3'b000, i_brightness};
            KIND_COLOUR: n_byte = i_rd_data;
            default:     n_byte = END_BYTE;
        endcase
    end

    // Output register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= n_byte;
            r_out_last <= r_s1.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;

endmodule

// ----- hw/rtl/rgbfg_checker.sv -----
// Port-level checker for the LED strip frame generator, bound to the top level.
module rgbfg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_stream_byte,
    input logic       o_last_byte
);

    import rgbfg_pkg::*;

    // No bytes come out in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // The flagged byte is always an end byte
    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_byte |-> o_stream_byte == END_BYTE)
        else $error("last byte flag on a non-end byte");

    // A refresh keeps the input stalled in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second refresh taken right after the first");

    // Stalled output byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_stream_byte) && $stable(o_last_byte))
        else $error("stalled output changed");

endmodule

bind rgb_led_strip_frame_generator_top rgbfg_checker u_rgbfg_checker (.*);
